// ----- src/mtl_pkg.sv -----
// ----------------------------------------------------------------------------
// mtl_pkg: shared types and constants of the markup token lexer
// Position width, result queue sizing, lexer modes, character codes and the
// token record that travels from the lexer core to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mtl_pkg;

  localparam int POSITION_BITS = 16;
  localparam int TOKEN_W       = 16;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [3:0] {
    MODE_SPACE  = 4'b0001,
    MODE_SQUOTE = 4'b0010,
    MODE_DQUOTE = 4'b0100,
    MODE_IDENT  = 4'b1000
  } mode_t;

  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef struct packed {
    logic               ovf;
    logic               last;
    logic [TOKEN_W-1:0] length;
    logic [TOKEN_W-1:0] offset;
  } tok_t;

  typedef struct packed {
    logic [1:0] count;
    tok_t       tok1;
    tok_t       tok0;
  } push_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return (c == CH_LT) || (c == CH_GT) || (c == CH_SLASH) || (c == CH_EQ);
  endfunction

endpackage

`default_nettype wire

// ----- src/mtl_core.sv -----
// ----------------------------------------------------------------------------
// mtl_core: input register and per-byte lexer step
// Holds one input beat, the lexer mode, escape flag, byte position, token
// start and overflow flag, and emits up to two tokens per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mtl_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_new,
  input  wire logic              room,
  output mtl_pkg::push_t         push
);

  logic                 stg_valid;
  logic [7:0]           stg_byte;
  logic                 stg_new;
  logic                 adv;

  mtl_pkg::mode_t       mode, mode_next;
  logic                 skip, skip_next;
  mtl_pkg::pos_t        pos, pos_next;
  mtl_pkg::pos_t        tbegin, tbegin_next;
  logic                 ovf, ovf_next;

  mtl_pkg::mode_t       eff_mode;
  logic                 eff_skip;
  mtl_pkg::pos_t        eff_pos;
  mtl_pkg::pos_t        eff_begin;
  logic                 eff_ovf;
  logic [7:0]           quote;
  logic [1:0]           n;
  mtl_pkg::pos_t        s0, e0, s1, e1;

  assign adv      = stg_valid && room;
  assign in_ready = !stg_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_byte <= in_byte;
      stg_new  <= in_new;
    end
  end

  always_comb begin
    eff_mode  = stg_new ? mtl_pkg::MODE_SPACE : mode;
    eff_skip  = stg_new ? 1'b0 : skip;
    eff_pos   = stg_new ? '0 : pos;
    eff_begin = stg_new ? '0 : tbegin;
    eff_ovf   = stg_new ? 1'b0 : ovf;
    pos_next  = eff_pos + mtl_pkg::POSITION_BITS'(1);
    quote     = (eff_mode == mtl_pkg::MODE_SQUOTE) ? mtl_pkg::CH_SQUOTE : mtl_pkg::CH_DQUOTE;

    mode_next   = eff_mode;
    skip_next   = eff_skip;
    tbegin_next = eff_begin;
    n  = 2'd0;
    s0 = eff_begin;
    e0 = pos_next;
    s1 = eff_pos;
    e1 = pos_next;

    if (eff_skip) begin
      skip_next = 1'b0;
    end else begin
      unique case (eff_mode) inside
        mtl_pkg::MODE_SQUOTE, mtl_pkg::MODE_DQUOTE: begin
          if (stg_byte == quote) begin
            n           = 2'd1;
            tbegin_next = pos_next;
            mode_next   = mtl_pkg::MODE_SPACE;
          end else if (stg_byte == mtl_pkg::CH_BSLASH) begin
            skip_next = 1'b1;
          end
        end
        mtl_pkg::MODE_IDENT: begin
          // An identifier ends just before the byte that closes it.
          e0 = eff_pos;
          if (mtl_pkg::is_space(stg_byte)) begin
            n           = 2'd1;
            tbegin_next = pos_next;
            mode_next   = mtl_pkg::MODE_SPACE;
          end else if (mtl_pkg::is_symbol(stg_byte)) begin
            n           = 2'd2;
            tbegin_next = pos_next;
            mode_next   = mtl_pkg::MODE_SPACE;
          end
        end
        default: begin
          mode_next = mtl_pkg::MODE_SPACE;
          if (stg_byte == mtl_pkg::CH_SQUOTE) begin
            mode_next = mtl_pkg::MODE_SQUOTE;
          end else if (stg_byte == mtl_pkg::CH_DQUOTE) begin
            mode_next = mtl_pkg::MODE_DQUOTE;
          end else if (mtl_pkg::is_symbol(stg_byte)) begin
            n           = 2'd1;
            tbegin_next = pos_next;
          end else if (mtl_pkg::is_space(stg_byte)) begin
            tbegin_next = pos_next;
          end else begin
            mode_next = mtl_pkg::MODE_IDENT;
          end
        end
      endcase
    end

    ovf_next = eff_ovf || (pos_next == '0);

    push.count       = adv ? n : 2'd0;
    push.tok0.offset = mtl_pkg::TOKEN_W'(s0);
    push.tok0.length = mtl_pkg::TOKEN_W'(e0 - s0);
    push.tok0.last   = (n == 2'd1);
    push.tok0.ovf    = eff_ovf;
    push.tok1.offset = mtl_pkg::TOKEN_W'(s1);
    push.tok1.length = mtl_pkg::TOKEN_W'(e1 - s1);
    push.tok1.last   = 1'b1;
    push.tok1.ovf    = eff_ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= mtl_pkg::MODE_SPACE;
      skip   <= 1'b0;
      pos    <= '0;
      tbegin <= '0;
      ovf    <= 1'b0;
    end else if (adv) begin
      mode   <= mode_next;
      skip   <= skip_next;
      pos    <= pos_next;
      tbegin <= tbegin_next;
      ovf    <= ovf_next;
    end
  end

  // Escapes only exist inside quoted strings.
  a_skip_in_quote: assert property (@(posedge clk) disable iff (rst)
    skip |-> (mode == mtl_pkg::MODE_SQUOTE || mode == mtl_pkg::MODE_DQUOTE))
    else $error("escape flag set outside a quoted string");

  // Two tokens from one byte only when an identifier meets a symbol.
  a_pair_from_ident: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (!stg_new && !skip && mode == mtl_pkg::MODE_IDENT
                              && mtl_pkg::is_symbol(stg_byte)))
    else $error("token pair outside identifier mode");

  // Overflow stays set until a new text is taken.
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    (ovf && !(adv && stg_new)) |=> ovf)
    else $error("overflow flag dropped without a new text");

endmodule

`default_nettype wire

// ----- src/mtl_out_queue.sv -----
// ----------------------------------------------------------------------------
// mtl_out_queue: result queue of the markup token lexer
// Takes up to two tokens a cycle given room; hands out one a cycle on out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mtl_out_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mtl_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mtl_pkg::tok_t       out_tok
);

  mtl_pkg::tok_t                  mem [mtl_pkg::Q_DEPTH];
  logic [mtl_pkg::Q_PTR_W-1:0]    wp, rp;
  logic [mtl_pkg::Q_PTR_W-1:0]    wp_plus1;
  logic [mtl_pkg::Q_CNT_W-1:0]    count;
  logic                           pop;

  assign room      = (count <= mtl_pkg::Q_CNT_W'(mtl_pkg::Q_DEPTH - 2));
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_tok   = mem[rp];
  assign wp_plus1  = wp + mtl_pkg::Q_PTR_W'(1);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wp] <= push.tok0;
    end
    if (push.count == 2'd2) begin
      mem[wp_plus1] <= push.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + mtl_pkg::Q_PTR_W'(push.count);
      rp    <= rp + mtl_pkg::Q_PTR_W'(pop);
      count <= count + mtl_pkg::Q_CNT_W'(push.count) - mtl_pkg::Q_CNT_W'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= mtl_pkg::Q_CNT_W'(mtl_pkg::Q_DEPTH))
    else $error("result queue overfilled");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> room)
    else $error("tokens pushed without room");

endmodule

`default_nettype wire

// ----- src/markup_token_lexer_unit.sv -----
// A byte accepted on s_* is held in the core's input register; its tokens are written into
// the result queue when the core advances and are presented on m_* from there.
// Throughput: one byte per cycle while each byte yields at most one token and m_tready is
// high; an identifier closed by a symbol yields two tokens, drained one per cycle.
// The four-entry result queue sets how far input runs ahead of a stalled output.
// Reset (rst, synchronous, active high) clears mode, position, flags and the queue.
// ----------------------------------------------------------------------------
// markup_token_lexer_unit: byte stream to markup token stream
// Splits markup text into symbol, quoted string and identifier tokens and
// reports each as a start offset and length.
// ----------------------------------------------------------------------------
`default_nettype none

module markup_token_lexer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
  input  wire logic        s_tuser,   // [0] new_text
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [15:0] token_offset, [31:16] token_length
  output logic             m_tlast,   // last_of_run
  output logic             m_tuser    // [0] position_overflow
);

  mtl_pkg::push_t push;
  logic           room;
  mtl_pkg::tok_t  out_tok;

  // The core registers each input beat, runs the lexer step on it and hands
  // zero, one or two tokens to the queue when the queue has room. It stalls
  // only when the queue cannot take a pair of tokens.
  mtl_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_new   (s_tuser),
    .room     (room),
    .push     (push)
  );

  // The queue decouples the output side, so a waiting result never blocks
  // the next input beat while there is space for its tokens.
  mtl_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_tok   (out_tok)
  );

  assign m_tdata = {out_tok.length, out_tok.offset};
  assign m_tlast = out_tok.last;
  assign m_tuser = out_tok.ovf;

endmodule

`default_nettype wire

// ----- sim/markup_token_lexer_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// markup_token_lexer_unit_tb: self-checking bench for the markup token lexer
// Streams markup text one byte per beat into the lexer and predicts every
// token from a behavioral lexer kept in the bench. It checks each output beat
// against the oldest prediction while both stream sides idle at random. It also
// covers a long receiver hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------

module markup_token_lexer_unit_tb;

  localparam int CYCLE_LIMIT = 1_000_000;

  // One input beat: the text byte plus the flag that opens a new text.
  typedef struct packed {
    logic       fresh;
    logic [7:0] text;
  } text_beat_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;  // [7:0] text_byte
  logic        s_tuser  = 1'b0;   // [0] new_text
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [15:0] token_offset, [31:16] token_length
  logic        m_tlast;           // last_of_run
  logic        m_tuser;           // [0] position_overflow

  markup_token_lexer_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bench-side copy of the lexer state. It advances on every accepted input
  // beat, in the driver process, so it always matches what the block has seen.
  mtl_pkg::mode_t lex_mode;
  logic           skip_escaped;
  mtl_pkg::pos_t  byte_pos;
  mtl_pkg::pos_t  tok_start;
  logic           ovf_flag;

  mtl_pkg::tok_t expected_tokens[$];
  text_beat_t    text_beats[$];
  text_beat_t    beat_out;
  mtl_pkg::tok_t want;

  int   fail_count        = 0;
  int   queued_total      = 0;
  int   cycle_count       = 0;
  int   sender_idle_pct   = 20;
  int   receiver_idle_pct = 54;
  int   hold_len          = 0;
  int   hold_id           = 0;
  int   hold_seen         = 0;
  int   hold_left         = 0;
  logic open_new_text     = 1'b0;

  function automatic logic blank_char(input logic [7:0] c);
    return c == mtl_pkg::CH_SPACE || c == mtl_pkg::CH_TAB ||
           c == mtl_pkg::CH_LF || c == mtl_pkg::CH_CR;
  endfunction

  function automatic logic symbol_char(input logic [7:0] c);
    return c == mtl_pkg::CH_LT || c == mtl_pkg::CH_GT ||
           c == mtl_pkg::CH_SLASH || c == mtl_pkg::CH_EQ;
  endfunction

  // A token running from 'from' up to, but not including, 'upto'. The length
  // wraps with the position counter, as the hardware does.
  function automatic mtl_pkg::tok_t token_span(input mtl_pkg::pos_t from,
                                               input mtl_pkg::pos_t upto);
    mtl_pkg::tok_t t;
    t.offset = mtl_pkg::TOKEN_W'(from);
    t.length = mtl_pkg::TOKEN_W'(mtl_pkg::pos_t'(upto - from));
    t.last   = 1'b0;
    t.ovf    = ovf_flag;
    return t;
  endfunction

  // Advances the lexer by one byte and queues the tokens that byte finishes.
  function automatic void predict_tokens(input logic [7:0] c, input logic fresh);
    mtl_pkg::tok_t found[2];
    int            n;
    mtl_pkg::pos_t p;
    mtl_pkg::pos_t nxt;
    logic [7:0]    closing;
    n = 0;
    // A new text drops any pending token and restarts all counting.
    if (fresh) begin
      lex_mode     = mtl_pkg::MODE_SPACE;
      skip_escaped = 1'b0;
      byte_pos     = '0;
      tok_start    = '0;
      ovf_flag     = 1'b0;
    end
    p   = byte_pos;
    nxt = p + 1'b1;
    if (skip_escaped) begin
      // The byte after a backslash in a string is consumed unseen.
      skip_escaped = 1'b0;
    end else begin
      case (lex_mode)
        mtl_pkg::MODE_SQUOTE, mtl_pkg::MODE_DQUOTE: begin
          closing = (lex_mode == mtl_pkg::MODE_SQUOTE) ? mtl_pkg::CH_SQUOTE
                                                       : mtl_pkg::CH_DQUOTE;
          if (c == closing) begin
            found[n] = token_span(tok_start, nxt);
            n++;
            tok_start = nxt;
            lex_mode  = mtl_pkg::MODE_SPACE;
          end else if (c == mtl_pkg::CH_BSLASH) begin
            skip_escaped = 1'b1;
          end
        end
        mtl_pkg::MODE_IDENT: begin
          if (blank_char(c)) begin
            found[n] = token_span(tok_start, p);
            n++;
            tok_start = nxt;
            lex_mode  = mtl_pkg::MODE_SPACE;
          end else if (symbol_char(c)) begin
            // The identifier and the symbol that ends it both come out.
            found[0] = token_span(tok_start, p);
            found[1] = token_span(p, nxt);
            n = 2;
            tok_start = nxt;
            lex_mode  = mtl_pkg::MODE_SPACE;
          end
        end
        default: begin
          lex_mode = mtl_pkg::MODE_SPACE;
          if (c == mtl_pkg::CH_SQUOTE) begin
            lex_mode = mtl_pkg::MODE_SQUOTE;
          end else if (c == mtl_pkg::CH_DQUOTE) begin
            lex_mode = mtl_pkg::MODE_DQUOTE;
          end else if (symbol_char(c)) begin
            found[n] = token_span(tok_start, nxt);
            n++;
            tok_start = nxt;
          end else if (blank_char(c)) begin
            tok_start = nxt;
          end else begin
            lex_mode = mtl_pkg::MODE_IDENT;
          end
        end
      endcase
    end
    if (n > 0) begin
      found[n-1].last = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      expected_tokens.push_back(found[k]);
    end
    // The flag is raised by the byte whose increment wraps, after its tokens.
    if (nxt == '0) begin
      ovf_flag = 1'b1;
    end
    byte_pos = nxt;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders. They only append to the queue of pending beats; the
  // driver below decides when each beat is offered.
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] c);
    text_beats.push_back({open_new_text, c});
    open_new_text = 1'b0;
    queued_total++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_byte(s[i]);
    end
  endtask

  // Any nonzero byte that stays inside an identifier, high bytes included.
  function automatic logic [7:0] ident_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (blank_char(c) || symbol_char(c) || c == mtl_pkg::CH_SQUOTE ||
               c == mtl_pkg::CH_DQUOTE || c == mtl_pkg::CH_BSLASH);
    return c;
  endfunction

  task automatic queue_ident();
    int n;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      queue_byte(ident_char());
    end
  endtask

  task automatic queue_blank();
    int n;
    logic [7:0] blanks[4];
    blanks = '{mtl_pkg::CH_SPACE, mtl_pkg::CH_TAB, mtl_pkg::CH_LF, mtl_pkg::CH_CR};
    n = $urandom_range(1, 2);
    for (int k = 0; k < n; k++) begin
      queue_byte(blanks[$urandom_range(0, 3)]);
    end
  endtask

  // A quoted string with random content and escapes; one in ten is left open
  // so that the following markup lands inside a string.
  task automatic queue_quoted();
    logic [7:0] q;
    logic [7:0] c;
    int n;
    q = $urandom_range(0, 1) ? mtl_pkg::CH_DQUOTE : mtl_pkg::CH_SQUOTE;
    queue_byte(q);
    n = $urandom_range(0, 8);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 5) == 0) begin
        queue_byte(mtl_pkg::CH_BSLASH);
        queue_byte(8'($urandom_range(1, 255)));
      end else begin
        c = 8'($urandom_range(1, 255));
        if (c != q && c != mtl_pkg::CH_BSLASH) begin
          queue_byte(c);
        end
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      queue_byte(q);
    end
  endtask

  // An element tag: opening, closing or empty, with quoted attributes.
  task automatic queue_element();
    int n_attr;
    queue_byte(mtl_pkg::CH_LT);
    if ($urandom_range(0, 3) == 0) begin
      queue_byte(mtl_pkg::CH_SLASH);
    end
    queue_ident();
    n_attr = $urandom_range(0, 2);
    for (int k = 0; k < n_attr; k++) begin
      queue_blank();
      queue_ident();
      queue_byte(mtl_pkg::CH_EQ);
      queue_quoted();
    end
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 1) != 0) begin
        queue_blank();
      end
      queue_byte(mtl_pkg::CH_SLASH);
    end
    queue_byte(mtl_pkg::CH_GT);
    if ($urandom_range(0, 1) != 0) begin
      queue_blank();
    end
  endtask

  // Mostly well-formed markup, with new texts started at random and some
  // raw noise bytes mixed in.
  task automatic queue_random_markup(input int amount);
    int target;
    int r;
    int n;
    target = queued_total + amount;
    while (queued_total < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        open_new_text = 1'b1;
      end else if (r < 55) begin
        queue_element();
      end else if (r < 70) begin
        queue_quoted();
      end else if (r < 85) begin
        queue_ident();
        queue_blank();
      end else begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          queue_byte(8'($urandom_range(1, 255)));
        end
      end
    end
  endtask

  // Holds the stimulus back until everything queued has been sent and every
  // predicted token has come out.
  task automatic wait_until_drained();
    while (text_beats.size() != 0 || s_tvalid || expected_tokens.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: on an accepted beat the prediction advances, then the next pending
  // beat is offered unless this cycle is chosen as a gap.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tuser  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_tokens(s_tdata, s_tuser);
      end
      if (!s_tvalid || s_tready) begin
        if (text_beats.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          beat_out = text_beats.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= beat_out.text;
          s_tuser  <= beat_out.fresh;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random backpressure, plus a long hold-off that the stimulus
  // requests by bumping hold_id. The hold-off is counted down here.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_id != hold_seen) begin
      hold_seen <= hold_id;
      hold_left <= hold_len;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Monitor: every accepted output beat is matched against the oldest token
  // still expected.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token beat: offset %0d length %0d", m_tdata[15:0], m_tdata[31:16]);
        fail_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (m_tdata[15:0] !== want.offset) begin
          $error("token_offset: expected %0d, got %0d", want.offset, m_tdata[15:0]);
          fail_count++;
        end
        if (m_tdata[31:16] !== want.length) begin
          $error("token_length: expected %0d, got %0d", want.length, m_tdata[31:16]);
          fail_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, m_tlast);
          fail_count++;
        end
        if (m_tuser !== want.ovf) begin
          $error("position_overflow: expected %0b, got %0b", want.ovf, m_tuser);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("markup_token_lexer_unit test failed");
      $finish;
    end
  end

  initial begin
    lex_mode     = mtl_pkg::MODE_SPACE;
    skip_escaped = 1'b0;
    byte_pos     = '0;
    tok_start    = '0;
    ovf_flag     = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed text: symbols, an identifier closed by a tab and one closed by
    // a symbol, an escaped quote and an escaped backslash inside strings, the
    // lowest nonzero and highest byte values inside identifiers, and all four blanks.
    open_new_text = 1'b1;
    queue_text("<a\tk=");
    queue_text("'x\\'y'");
    queue_text("\"\\\\\"");
    queue_byte(8'hFF);
    queue_byte(mtl_pkg::CH_SLASH);
    queue_byte(8'h01);
    queue_byte(mtl_pkg::CH_CR);
    queue_byte(mtl_pkg::CH_GT);
    queue_byte(mtl_pkg::CH_LF);
    // A pending identifier is dropped when a new text starts.
    queue_byte("b");
    open_new_text = 1'b1;
    queue_text("c ");
    // A new text also cancels a pending escape, so this symbol is seen.
    queue_text("'\\");
    open_new_text = 1'b1;
    queue_byte(mtl_pkg::CH_GT);

    // Sender gaps are light and receiver stalls heavy in this phase.
    queue_random_markup(520);
    wait_until_drained();

    sender_idle_pct   = 54;
    receiver_idle_pct = 20;
    queue_random_markup(520);
    wait_until_drained();

    // No idling from here on. First the receiver holds off for a long stretch
    // while the sender keeps offering identifier-symbol pairs, which fills the
    // result queue and stalls the input side.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_len = 300;
    hold_id++;
    open_new_text = 1'b1;
    for (int k = 0; k < 20; k++) begin
      queue_text("ab=");
    end
    wait_until_drained();

    queue_random_markup(420);
    wait_until_drained();

    // Let any beat that was still in flight show itself before the verdict.
    repeat (8) @(negedge clk);
    if (fail_count == 0 && expected_tokens.size() == 0) begin
      $display("markup_token_lexer_unit test passed");
    end else begin
      $display("markup_token_lexer_unit test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/mtl_pkg.sv
src/mtl_core.sv
src/mtl_out_queue.sv
src/markup_token_lexer_unit.sv
sim/markup_token_lexer_unit_tb.sv
